>>> rtl/core/bcdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Button decoder package
// Shared types, register indexes, event codes and reset values for the
// button click, double click and hold decoder.
// ----------------------------------------------------------------------------
package bcdh_pkg;

  // Default width of the wrapped time arithmetic.
  localparam int TIME_BITS_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 12;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_HOLD_MS      = 3'd1,
    CFG_DOUBLE_WIN   = 3'd2,
    CFG_RAMP_STEP    = 3'd3,
    CFG_BRIGHT_FLOOR = 3'd4,
    CFG_FX_COUNT     = 3'd5,
    CFG_SPEED_COUNT  = 3'd6
  } cfg_idx_t;

  // Event codes reported with each result.
  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_EFFECT = 2'd1,
    EVT_SPEED  = 2'd2,
    EVT_HOLD   = 2'd3
  } event_t;

  // Register reset values.
  localparam logic [7:0]  DEBOUNCE_RST     = 8'd20;
  localparam logic [11:0] HOLD_MS_RST      = 12'd400;
  localparam logic [11:0] DOUBLE_WIN_RST   = 12'd300;
  localparam logic [9:0]  RAMP_STEP_RST    = 10'd38;
  localparam logic [7:0]  BRIGHT_FLOOR_RST = 8'd8;
  localparam logic [2:0]  FX_COUNT_RST     = 3'd3;
  localparam logic [2:0]  SPEED_COUNT_RST  = 3'd3;

  // Brightness in 8.8 fixed point.
  localparam logic [15:0] LEVEL_RST = 16'd32768;
  localparam logic [15:0] LEVEL_MAX = 16'd65280;

  // One input sample.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [6:0]  elapsed_ms;
    logic        button_down;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [1:0] effect_index;
    logic [1:0] speed_index;
    logic [7:0] brightness;
    logic       ramp_active;
    logic       ramp_up;
    logic       button_state;
    logic [1:0] event_res;
  } out_item_t;

  // Step a selection index, wrapping to zero at the count.
  function automatic logic [1:0] advance(input logic [1:0] sel, input logic [2:0] count);
    logic [2:0] n;
    n = {1'b0, sel} + 3'd1;
    if (n >= count) begin
      advance = 2'd0;
    end else begin
      advance = n[1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/button_click_double_hold_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Button click, double click and hold decoder
// Debounces a sampled button, classifies clicks, double clicks and holds,
// and ramps an 8.8 fixed-point brightness while the button is held.
// ----------------------------------------------------------------------------
// The block takes one button sample per clock cycle while in_stall is low
// and produces exactly one result per sample. The whole decision for a
// sample is made in one pass of logic from the state registers and the
// sample into the state registers and the output or skid register. A
// two-entry output buffer (output register plus a skid register) keeps
// input acceptance going while a result waits; in_stall is raised only
// when both entries hold results. The ramp product is a single 10 by 7
// bit multiply. Configuration writes are always ready and take effect on
// the next sample; they are to be made while the block is idle.
module button_click_double_hold_decoder_core
  import bcdh_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  in_item_t           in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output out_item_t                out_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [CFG_DATA_BITS-1:0] cfg_data
);

  typedef logic [TIME_BITS-1:0] time_t;

  // Configuration registers.
  logic [7:0]  debounce_time;
  logic [11:0] hold_ms;
  logic [11:0] double_win;
  logic [9:0]  ramp_step;
  logic [7:0]  bright_floor;
  logic [2:0]  fx_count;
  logic [2:0]  speed_count;

  // Decoder state.
  logic       raw_last, stable_level, holding, click_waiting, double_seen, going_up;
  time_t      change_time, press_time, click_time;
  logic [15:0] level_fixed;
  logic [1:0] effect_sel, speed_sel;

  logic       raw_last_next, stable_level_next, holding_next, click_waiting_next;
  logic       double_seen_next, going_up_next;
  time_t      change_time_next, press_time_next, click_time_next;
  logic [15:0] level_fixed_next;
  logic [1:0] effect_sel_next, speed_sel_next;
  event_t     evt;

  // Output buffer.
  out_item_t  skid_data;
  logic       skid_valid;
  out_item_t  result;

  logic  accept, out_take;
  time_t now;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign now       = in_data.now_ms[TIME_BITS-1:0];

  // Configuration write transactions.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RST;
      hold_ms       <= HOLD_MS_RST;
      double_win    <= DOUBLE_WIN_RST;
      ramp_step     <= RAMP_STEP_RST;
      bright_floor  <= BRIGHT_FLOOR_RST;
      fx_count      <= FX_COUNT_RST;
      speed_count   <= SPEED_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:     debounce_time <= cfg_data[7:0];
        CFG_HOLD_MS:      hold_ms       <= cfg_data[11:0];
        CFG_DOUBLE_WIN:   double_win    <= cfg_data[11:0];
        CFG_RAMP_STEP:    ramp_step     <= cfg_data[9:0];
        CFG_BRIGHT_FLOOR: bright_floor  <= cfg_data[7:0];
        CFG_FX_COUNT:     fx_count      <= cfg_data[2:0];
        CFG_SPEED_COUNT:  speed_count   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Per-sample decode: debounce, click classification, hold and ramp.
  always_comb begin
    time_t             deb_age, click_age, press_age;
    logic              deb_fire;
    logic [16:0]       delta;
    logic signed [18:0] lv, fl;

    raw_last_next      = raw_last;
    stable_level_next  = stable_level;
    holding_next       = holding;
    click_waiting_next = click_waiting;
    double_seen_next   = double_seen;
    going_up_next      = going_up;
    change_time_next   = change_time;
    press_time_next    = press_time;
    click_time_next    = click_time;
    level_fixed_next   = level_fixed;
    effect_sel_next    = effect_sel;
    speed_sel_next     = speed_sel;
    evt                = EVT_NONE;

    // Track the time of the last raw level change.
    if (in_data.button_down != raw_last) begin
      change_time_next = now;
      raw_last_next    = in_data.button_down;
    end

    deb_age  = now - change_time_next;
    deb_fire = (deb_age >= time_t'(debounce_time)) && (in_data.button_down != stable_level);

    // Debounced edges.
    click_age = now - click_time;
    press_age = now - press_time;
    if (deb_fire) begin
      stable_level_next = in_data.button_down;
      if (in_data.button_down) begin
        press_time_next = now;
        if (click_waiting && (click_age <= time_t'(double_win))) begin
          click_waiting_next = 1'b0;
          double_seen_next   = 1'b1;
          speed_sel_next     = advance(speed_sel, speed_count);
          evt                = EVT_SPEED;
        end else begin
          double_seen_next = 1'b0;
        end
      end else begin
        if (holding) begin
          holding_next  = 1'b0;
          going_up_next = !going_up;
        end else if (!double_seen && (press_age < time_t'(hold_ms))) begin
          click_waiting_next = 1'b1;
          click_time_next    = now;
        end
      end
    end

    // Hold detection uses the press time as updated above.
    press_age = now - press_time_next;
    if (stable_level_next && !holding_next && !double_seen_next &&
        (press_age >= time_t'(hold_ms))) begin
      holding_next       = 1'b1;
      click_waiting_next = 1'b0;
      evt                = EVT_HOLD;
    end

    // Brightness ramp, saturated to the ceiling and then to the floor.
    delta = {7'd0, ramp_step} * {10'd0, in_data.elapsed_ms};
    fl    = $signed({3'b000, bright_floor, 8'h00});
    if (going_up_next) begin
      lv = $signed({3'b000, level_fixed}) + $signed({2'b00, delta});
    end else begin
      lv = $signed({3'b000, level_fixed}) - $signed({2'b00, delta});
    end
    if (lv > $signed({3'b000, LEVEL_MAX})) begin
      lv = $signed({3'b000, LEVEL_MAX});
    end
    if (lv < fl) begin
      lv = fl;
    end
    if (holding_next) begin
      level_fixed_next = lv[15:0];
    end

    // Pending single click expires into an effect step.
    click_age = now - click_time_next;
    if (click_waiting_next && (click_age > time_t'(double_win))) begin
      click_waiting_next = 1'b0;
      effect_sel_next    = advance(effect_sel, fx_count);
      evt                = EVT_EFFECT;
    end

    result.effect_index = effect_sel_next;
    result.speed_index  = speed_sel_next;
    result.brightness   = level_fixed_next[15:8];
    result.ramp_active  = holding_next;
    result.ramp_up      = going_up_next;
    result.button_state = stable_level_next;
    result.event_res    = evt;
  end

  // State update on each input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last      <= 1'b0;
      stable_level  <= 1'b0;
      holding       <= 1'b0;
      click_waiting <= 1'b0;
      double_seen   <= 1'b0;
      going_up      <= 1'b1;
      change_time   <= '0;
      press_time    <= '0;
      click_time    <= '0;
      level_fixed   <= LEVEL_RST;
      effect_sel    <= 2'd0;
      speed_sel     <= 2'd0;
    end else if (accept) begin
      raw_last      <= raw_last_next;
      stable_level  <= stable_level_next;
      holding       <= holding_next;
      click_waiting <= click_waiting_next;
      double_seen   <= double_seen_next;
      going_up      <= going_up_next;
      change_time   <= change_time_next;
      press_time    <= press_time_next;
      click_time    <= click_time_next;
      level_fixed   <= level_fixed_next;
      effect_sel    <= effect_sel_next;
      speed_sel     <= speed_sel_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/bcdh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button decoder result checker
// Watches the sample, result and register channels of the button decoder,
// predicts every result from its own copy of the decoder state and compares
// each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bcdh_checker
  import bcdh_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  wire                      in_stall,
  input  in_item_t                 in_data,
  input  wire                      out_valid,
  input  wire                      out_stall,
  input  out_item_t                out_data,
  input  wire                      cfg_valid,
  input  wire                      cfg_ready,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fails,
  output int                       pending,
  output int                       checked,
  output int                       n_effect,
  output int                       n_speed,
  output int                       n_hold
);

  // Register copies.
  logic [7:0]  cfg_debounce;
  logic [11:0] cfg_hold;
  logic [11:0] cfg_double;
  logic [9:0]  cfg_step;
  logic [7:0]  cfg_floor;
  logic [2:0]  cfg_effect_cnt;
  logic [2:0]  cfg_speed_cnt;

  // Decoder state copies.
  logic        raw_prev;
  logic        debounced;
  logic [31:0] change_at;
  logic [31:0] press_at;
  logic [31:0] click_at;
  logic        holding;
  logic        click_pend;
  logic        double_seen;
  logic        going_up;
  logic [15:0] level;
  logic [1:0]  effect_sel;
  logic [1:0]  speed_sel;

  // Results decoded from accepted samples, oldest first.
  out_item_t   decoded_q[$];
  int          fail_n = 0;
  int          pending_n = 0;
  int          checked_n = 0;
  int          effect_n = 0;
  int          speed_n = 0;
  int          hold_n = 0;

  assign fails    = fail_n;
  assign pending  = pending_n;
  assign checked  = checked_n;
  assign n_effect = effect_n;
  assign n_speed  = speed_n;
  assign n_hold   = hold_n;

  // Prints one mismatch line and counts it.
  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_n++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("result %0d field %s is %0d, expected %0d", checked_n, name, got, want));
    end
  endtask

  // Steps a selection index, returning to zero at the count.
  function automatic logic [1:0] bump_index(input logic [1:0] sel, input logic [2:0] count);
    logic [2:0] nxt;
    nxt = {1'b0, sel} + 3'd1;
    return (nxt >= count) ? 2'd0 : nxt[1:0];
  endfunction

  // Decodes one sample: debounce, click and double click classification,
  // hold detection and the saturated brightness ramp.
  task automatic decode_sample(input in_item_t s, output out_item_t r);
    event_t evt;
    int     lvl;
    int     delta;
    evt = EVT_NONE;
    if (s.button_down != raw_prev) begin
      change_at = s.now_ms;
      raw_prev  = s.button_down;
    end

    // A level that stayed put long enough becomes the debounced level.
    if ((s.now_ms - change_at) >= cfg_debounce && s.button_down != debounced) begin
      debounced = s.button_down;
      if (debounced) begin
        press_at = s.now_ms;
        if (click_pend && (s.now_ms - click_at) <= cfg_double) begin
          click_pend  = 1'b0;
          double_seen = 1'b1;
          speed_sel   = bump_index(speed_sel, cfg_speed_cnt);
          evt         = EVT_SPEED;
        end else begin
          double_seen = 1'b0;
        end
      end else if (holding) begin
        holding  = 1'b0;
        going_up = ~going_up;
      end else if (!double_seen && (s.now_ms - press_at) < cfg_hold) begin
        click_pend = 1'b1;
        click_at   = s.now_ms;
      end
    end

    // A long enough press starts a hold.
    if (debounced && !holding && !double_seen && (s.now_ms - press_at) >= cfg_hold) begin
      holding    = 1'b1;
      click_pend = 1'b0;
      evt        = EVT_HOLD;
    end

    // Ramp the level, capped at full scale and then lifted to the floor.
    if (holding) begin
      delta = int'(cfg_step) * int'(s.elapsed_ms);
      lvl   = going_up ? int'(level) + delta : int'(level) - delta;
      if (lvl > int'(LEVEL_MAX)) begin
        lvl = int'(LEVEL_MAX);
      end
      if (lvl < int'(cfg_floor) * 256) begin
        lvl = int'(cfg_floor) * 256;
      end
      level = lvl[15:0];
    end

    // A click with no second press inside the window advances the effect.
    if (click_pend && (s.now_ms - click_at) > cfg_double) begin
      click_pend = 1'b0;
      effect_sel = bump_index(effect_sel, cfg_effect_cnt);
      evt        = EVT_EFFECT;
    end

    case (evt)
      EVT_EFFECT: effect_n++;
      EVT_SPEED:  speed_n++;
      EVT_HOLD:   hold_n++;
      default: ;
    endcase

    r.effect_index = effect_sel;
    r.speed_index  = speed_sel;
    r.brightness   = level[15:8];
    r.ramp_active  = holding;
    r.ramp_up      = going_up;
    r.button_state = debounced;
    r.event_res    = evt;
  endtask

  // Per edge: predict accepted samples, compare accepted results, then
  // apply register writes so that they hold from the next sample on.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      cfg_debounce   = DEBOUNCE_RST;
      cfg_hold       = HOLD_MS_RST;
      cfg_double     = DOUBLE_WIN_RST;
      cfg_step       = RAMP_STEP_RST;
      cfg_floor      = BRIGHT_FLOOR_RST;
      cfg_effect_cnt = FX_COUNT_RST;
      cfg_speed_cnt  = SPEED_COUNT_RST;
      raw_prev       = 1'b0;
      debounced      = 1'b0;
      change_at      = '0;
      press_at       = '0;
      click_at       = '0;
      holding        = 1'b0;
      click_pend     = 1'b0;
      double_seen    = 1'b0;
      going_up       = 1'b1;
      level          = LEVEL_RST;
      effect_sel     = '0;
      speed_sel      = '0;
      decoded_q.delete();
      pending_n <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_sample(in_data, want);
        decoded_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("result %0d arrived with no sample outstanding", checked_n));
        end else begin
          want = decoded_q.pop_front();
          check_field("effect_index", out_data.effect_index, want.effect_index);
          check_field("speed_index", out_data.speed_index, want.speed_index);
          check_field("brightness", out_data.brightness, want.brightness);
          check_field("ramp_active", out_data.ramp_active, want.ramp_active);
          check_field("ramp_up", out_data.ramp_up, want.ramp_up);
          check_field("button_state", out_data.button_state, want.button_state);
          check_field("event_res", out_data.event_res, want.event_res);
        end
        checked_n++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE:     cfg_debounce   = cfg_data[7:0];
          CFG_HOLD_MS:      cfg_hold       = cfg_data[11:0];
          CFG_DOUBLE_WIN:   cfg_double     = cfg_data[11:0];
          CFG_RAMP_STEP:    cfg_step       = cfg_data[9:0];
          CFG_BRIGHT_FLOOR: cfg_floor      = cfg_data[7:0];
          CFG_FX_COUNT:     cfg_effect_cnt = cfg_data[2:0];
          CFG_SPEED_COUNT:  cfg_speed_cnt  = cfg_data[2:0];
          default: ;
        endcase
      end
      pending_n <= decoded_q.size();
    end
  end

endmodule

>>> tb/sv/tb_button_click_double_hold_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button decoder testbench
// Drives button sample sequences (clicks, double clicks, holds, bounce and
// noise) through the decoder under several register settings, with random
// idling on both channels; the checker beside the block judges the results.
// ----------------------------------------------------------------------------
module tb_button_click_double_hold_decoder_core;
  import bcdh_pkg::*;

  localparam int LIMIT      = 600000;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 150;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  logic                     rx_stall = 1'b0;
  logic                     rx_hold = 1'b0;
  int                       rx_left = 0;
  int                       cycle_n = 0;

  int fails, pending, checked, n_effect, n_speed, n_hold;

  // Stimulus state: sample time, register mirror used to shape gestures.
  logic [31:0] now_t = '0;
  int          sent_n = 0;
  int          db = 20;
  int          hd = 400;
  int          dbl = 300;
  int          max_step = 30;
  bit          burst = 1'b0;

  always #5 clk = ~clk;

  button_click_double_hold_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcdh_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked),
    .n_effect  (n_effect),
    .n_speed   (n_speed),
    .n_hold    (n_hold)
  );

  // Result side stalls: free stretches, short stalls and a few long ones.
  assign out_stall = rx_stall | rx_hold;

  always @(posedge clk) begin : rx_idle
    int r;
    if (rst) begin
      rx_stall <= 1'b0;
      rx_left  <= 0;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        rx_stall <= 1'b0;
        rx_left  <= $urandom_range(0, 30);
      end else if (r < 92) begin
        rx_stall <= 1'b1;
        rx_left  <= $urandom_range(0, 3);
      end else begin
        rx_stall <= 1'b1;
        rx_left  <= $urandom_range(10, 40);
      end
    end
  end

  // One long receiver hold-off while samples keep coming, so the block fills.
  initial begin
    wait (sent_n >= 450);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= LIMIT) begin
      $display("** button_click_double_hold_decoder_core: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Milliseconds between samples: mostly small, sometimes zero or over 100.
  function automatic logic [6:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return 7'd0;
    end
    if (r < 6) begin
      return 7'($urandom_range(101, 127));
    end
    return 7'($urandom_range(1, max_step));
  endfunction

  // Offers one sample transaction and returns at the edge that accepts it.
  task automatic send_sample(input logic [31:0] t, input logic [6:0] e, input logic b);
    int gap;
    gap   = pick_gap();
    now_t = t;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{now_ms: t, elapsed_ms: e, button_down: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_n++;
  endtask

  // Holds a level for about dur milliseconds.
  task automatic hold_level(input logic b, input int dur);
    int         left;
    logic [6:0] e;
    left = dur;
    while (left > 0) begin
      e = pick_step();
      send_sample(now_t + e, e, b);
      left -= e;
    end
  endtask

  // Contact bounce, then the level held for dur milliseconds.
  task automatic settle_level(input logic b, input int dur);
    int         n;
    logic [6:0] e;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      e = 7'($urandom_range(0, (db / 2 > 127) ? 127 : db / 2));
      send_sample(now_t + e, e, (i % 2 == 0) ? b : ~b);
    end
    hold_level(b, dur);
  endtask

  // Stops offering samples and waits until every result has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes a full register set for one phase while the block is idle.
  task automatic set_phase(input int p);
    int fl, stp, ec, sc;
    wait_idle();
    case (p)
      0: begin db = 5;   hd = 60;   dbl = 50;   stp = 200;  fl = 8;   ec = 3; sc = 3;
               max_step = 6;   burst = 1'b0; end
      1: begin db = 0;   hd = 1;    dbl = 0;    stp = 1023; fl = 255; ec = 1; sc = 1;
               max_step = 4;   burst = 1'b1; end
      2: begin db = 255; hd = 4095; dbl = 4095; stp = 0;    fl = 0;   ec = 4; sc = 4;
               max_step = 100; burst = 1'b0; end
      3: begin db = 10;  hd = 80;   dbl = 120;  stp = 1023; fl = 0;   ec = 4; sc = 2;
               max_step = 8;   burst = 1'b0; end
      4: begin db = 3;   hd = 40;   dbl = 40;   stp = 17;   fl = 200; ec = 2; sc = 4;
               max_step = 5;   burst = 1'b1; end
      5: begin db = 0;   hd = 0;    dbl = 20;   stp = 500;  fl = 30;  ec = 3; sc = 3;
               max_step = 5;   burst = 1'b0; end
      6: begin db = 4;   hd = 50;   dbl = 60;   stp = 300;  fl = 8;   ec = 7; sc = 0;
               max_step = 5;   burst = 1'b0; end
      default: begin db = 20; hd = 400; dbl = 300; stp = 38; fl = 8; ec = 3; sc = 3;
               max_step = 30;  burst = 1'b0; end
    endcase
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_HOLD_MS, hd);
    write_reg(CFG_DOUBLE_WIN, dbl);
    write_reg(CFG_RAMP_STEP, stp);
    write_reg(CFG_BRIGHT_FLOOR, fl);
    write_reg(CFG_FX_COUNT, ec);
    write_reg(CFG_SPEED_COUNT, sc);
    cfg_valid <= 1'b0;
    // Start near the time wrap in some phases, anywhere in others.
    if ($urandom_range(0, 1) == 0) begin
      now_t = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
    end else begin
      now_t = $urandom;
    end
  endtask

  // Stimulus.
  initial begin
    int         g, phase_end;
    logic [6:0] e;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under reset settings: hold with wrap, release flip,
    // double click, long press after double click, single click timeout.
    send_sample(32'd0, 7'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 7'd127, 1'b1);
    send_sample(32'd19, 7'd20, 1'b1);
    send_sample(32'd419, 7'd100, 1'b1);
    send_sample(32'd519, 7'd127, 1'b1);
    send_sample(32'd520, 7'd0, 1'b0);
    send_sample(32'd540, 7'd20, 1'b0);
    send_sample(32'd545, 7'd5, 1'b1);
    send_sample(32'd565, 7'd20, 1'b1);
    send_sample(32'd600, 7'd35, 1'b0);
    send_sample(32'd620, 7'd20, 1'b0);
    send_sample(32'd630, 7'd10, 1'b1);
    send_sample(32'd650, 7'd20, 1'b1);
    send_sample(32'd700, 7'd50, 1'b1);
    send_sample(32'd1200, 7'd100, 1'b1);
    send_sample(32'd1201, 7'd1, 1'b0);
    send_sample(32'd1221, 7'd20, 1'b0);
    send_sample(32'd1230, 7'd9, 1'b1);
    send_sample(32'd1250, 7'd20, 1'b1);
    send_sample(32'd1260, 7'd10, 1'b0);
    send_sample(32'd1280, 7'd20, 1'b0);
    send_sample(32'd1580, 7'd100, 1'b0);
    send_sample(32'd1581, 7'd1, 1'b0);

    // Random gestures under each register setting.
    for (int p = 0; p < N_PHASES; p++) begin
      set_phase(p);
      phase_end = sent_n + PHASE_ITEMS;
      while (sent_n < phase_end) begin
        g = $urandom_range(0, 99);
        if (g < 30) begin
          // Single click.
          settle_level(1'b1, db + $urandom_range(0, hd));
          settle_level(1'b0, db + $urandom_range(0, dbl + dbl / 2 + 10));
        end else if (g < 55) begin
          // Double click, sometimes with the second press turning into a hold.
          settle_level(1'b1, db + $urandom_range(0, hd / 2));
          settle_level(1'b0, db + $urandom_range(0, dbl));
          settle_level(1'b1, db + $urandom_range(0, hd + hd / 2));
          settle_level(1'b0, db + $urandom_range(dbl, 2 * dbl + 20));
        end else if (g < 80) begin
          // Hold that ramps the brightness.
          settle_level(1'b1, db + hd + $urandom_range(0, 2 * hd + 100));
          settle_level(1'b0, db + $urandom_range(0, 2 * dbl + 20));
        end else begin
          // Noise, with the odd jump of the sample time.
          repeat ($urandom_range(1, 8)) begin
            e = pick_step();
            send_sample(($urandom_range(0, 9) == 0) ? $urandom : now_t + e, e,
                        1'($urandom_range(0, 1)));
          end
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d samples over %0d register settings; %0d results checked.",
             sent_n, N_PHASES + 1, checked);
    $display("Decoded %0d effect steps, %0d speed steps and %0d hold starts.",
             n_effect, n_speed, n_hold);
    if (fails == 0) begin
      $display("** button_click_double_hold_decoder_core: PASSED **");
    end else begin
      $display("** button_click_double_hold_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
